// ----- sv/pid_temperature_fan_drive_macros.svh -----
// ----------------------------------------------------------------------------
// PID fan drive assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PID_TEMPERATURE_FAN_DRIVE_MACROS_SVH
`define PID_TEMPERATURE_FAN_DRIVE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PTFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define PTFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ptfd_pkg.sv -----
// ----------------------------------------------------------------------------
// PID fan drive package
// Shared types, register indexes and the sequencer program.
// ----------------------------------------------------------------------------
package ptfd_pkg;

   localparam int PC_W      = 3;
   localparam int GAIN_W    = 8;
   localparam int DRIVE_W   = 8;
   localparam int CSR_IDX_W = 4;
   localparam int Q_FRAC    = 10;

   localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd255;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 4'd3;

   localparam logic [GAIN_W-1:0] RST_GAIN_P = 8'd15;
   localparam logic [GAIN_W-1:0] RST_GAIN_I = 8'd0;
   localparam logic [GAIN_W-1:0] RST_GAIN_D = 8'd0;
   localparam logic [GAIN_W-1:0] RST_TARGET = 8'd10;

   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_ERR  = 2'd1,
      MUL_CHG  = 2'd2,
      MUL_SUM  = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_CLR  = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   // One control word of the program.
   typedef struct packed {
      logic            wait_in;    // hold here until an input beat arrives
      logic            wait_out;   // hold here until the result register frees
      logic            ld_err;     // capture the error of the incoming sample
      logic            upd_state;  // update change, sum and last error
      mul_sel_type     mul_sel;
      acc_op_type      acc_op;
      logic            emit;       // load the result register
      logic            jmp;
      logic [PC_W-1:0] target;
   } ctrl_type;

   // Status flags back to the sequencer.
   typedef struct packed {
      logic in_valid;
      logic out_free;
   } cond_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [GAIN_W-1:0] target;
   } cfg_type;

   localparam logic [PC_W-1:0] STEP_FETCH = 3'd0;
   localparam logic [PC_W-1:0] STEP_STATE = 3'd1;
   localparam logic [PC_W-1:0] STEP_MUL_P = 3'd2;
   localparam logic [PC_W-1:0] STEP_MUL_D = 3'd3;
   localparam logic [PC_W-1:0] STEP_MUL_I = 3'd4;
   localparam logic [PC_W-1:0] STEP_ACC_I = 3'd5;
   localparam logic [PC_W-1:0] STEP_EMIT  = 3'd6;

   // Program ROM.
   function automatic ctrl_type prog_word(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '{wait_in: 1'b0, wait_out: 1'b0, ld_err: 1'b0, upd_state: 1'b0,
            mul_sel: MUL_NONE, acc_op: ACC_HOLD, emit: 1'b0, jmp: 1'b0,
            target: STEP_FETCH};
      unique case (pc)
         STEP_FETCH: begin
            w.wait_in = 1'b1;
            w.ld_err  = 1'b1;
         end
         STEP_STATE: w.upd_state = 1'b1;
         STEP_MUL_P: begin
            w.mul_sel = MUL_ERR;
            w.acc_op  = ACC_CLR;
         end
         STEP_MUL_D: begin
            w.mul_sel = MUL_CHG;
            w.acc_op  = ACC_ADD;
         end
         STEP_MUL_I: begin
            w.mul_sel = MUL_SUM;
            w.acc_op  = ACC_ADD;
         end
         STEP_ACC_I: w.acc_op = ACC_ADD;
         STEP_EMIT: begin
            w.wait_out = 1'b1;
            w.emit     = 1'b1;
            w.jmp      = 1'b1;
            w.target   = STEP_FETCH;
         end
         default: begin
            w.jmp    = 1'b1;
            w.target = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- sv/ptfd_sequencer.sv -----
// ----------------------------------------------------------------------------
// PID fan drive sequencer
// Step counter over the program ROM with wait and jump control.
// ----------------------------------------------------------------------------
module ptfd_sequencer
   import ptfd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cond_type cond,
   output ctrl_type ctrl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            hold;

   assign ctrl = prog_word(pc_ff);

   // A waiting step stays put until its condition is met.
   assign hold = (ctrl.wait_in && !cond.in_valid) || (ctrl.wait_out && !cond.out_free);

   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (ctrl.jmp) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- sv/ptfd_datapath.sv -----
// ----------------------------------------------------------------------------
// PID fan drive datapath
// Error, saturating sum, one shared gain multiplier and the result register.
// ----------------------------------------------------------------------------
module ptfd_datapath
   import ptfd_pkg::*;
#(
   parameter int ADC_BITS  = 10,
   parameter int SUM_WIDTH = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  logic [ADC_BITS-1:0] adc,
   input  logic                out_ready,
   output logic                out_valid,
   output logic [DRIVE_W-1:0]  out_drive,
   output cond_type            cond
);

   localparam int ERR_W   = ADC_BITS + 11;
   localparam int CHG_W   = ERR_W + 1;
   // Sum operand is limited to +/-2^LIM_EXP: beyond that the integral term
   // outweighs the other two and the drive is pinned at 0 or 255 anyway.
   localparam int LIM_EXP = ADC_BITS + 19;
   localparam int TERM_W  = LIM_EXP + 2;
   localparam int PROD_W  = TERM_W + GAIN_W + 1;
   localparam int ACC_W   = PROD_W + 2;
   localparam int SAT_W   = (SUM_WIDTH > ERR_W ? SUM_WIDTH : ERR_W) + 1;
   localparam int CLP_W   = (SUM_WIDTH > TERM_W ? SUM_WIDTH : TERM_W);

   localparam logic signed [SAT_W-1:0] SUM_MAX =
      {{(SAT_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SUM_MIN =
      {{(SAT_W-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};
   localparam logic signed [CLP_W-1:0] LIM_POS = CLP_W'(1) << LIM_EXP;
   localparam logic signed [CLP_W-1:0] LIM_NEG = -LIM_POS;

   logic signed [ERR_W-1:0]     err_ff;
   logic signed [ERR_W-1:0]     err_in;
   logic signed [ERR_W-1:0]     last_err_ff;
   logic signed [CHG_W-1:0]     chg_ff;
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic signed [SUM_WIDTH-1:0] sum_in;
   logic signed [SAT_W-1:0]     sum_wide;
   logic signed [CLP_W-1:0]     sum_x;
   logic signed [TERM_W-1:0]    sumc_ff;
   logic signed [TERM_W-1:0]    sumc_in;
   logic signed [TERM_W-1:0]    mul_op;
   logic [GAIN_W-1:0]           mul_gain;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     acc_in;
   logic [ERR_W-1:0]            temp_ext;
   logic [ERR_W-1:0]            tgt_q10;
   logic [DRIVE_W-1:0]          drive;
   logic                        out_valid_ff;
   logic [DRIVE_W-1:0]          out_drive_ff;
   logic                        out_free;

   // adc * 500 = adc * 512 - adc * 8 - adc * 4
   assign temp_ext = ERR_W'(adc);
   assign tgt_q10  = ERR_W'(cfg.target) << Q_FRAC;
   assign err_in   = signed'((temp_ext << 9) - (temp_ext << 3) - (temp_ext << 2) - tgt_q10);

   assign sum_wide = SAT_W'(sum_ff) + SAT_W'(err_ff);

   always_comb begin
      if (sum_wide > SUM_MAX) begin
         sum_in = SUM_MAX[SUM_WIDTH-1:0];
      end else if (sum_wide < SUM_MIN) begin
         sum_in = SUM_MIN[SUM_WIDTH-1:0];
      end else begin
         sum_in = sum_wide[SUM_WIDTH-1:0];
      end
   end

   assign sum_x = CLP_W'(sum_ff);

   always_comb begin
      if (sum_x > LIM_POS) begin
         sumc_in = LIM_POS[TERM_W-1:0];
      end else if (sum_x < LIM_NEG) begin
         sumc_in = LIM_NEG[TERM_W-1:0];
      end else begin
         sumc_in = sum_x[TERM_W-1:0];
      end
   end

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_ERR: begin
            mul_op   = TERM_W'(err_ff);
            mul_gain = cfg.gain_p;
         end
         MUL_CHG: begin
            mul_op   = TERM_W'(chg_ff);
            mul_gain = cfg.gain_d;
         end
         MUL_SUM: begin
            mul_op   = sumc_ff;
            mul_gain = cfg.gain_i;
         end
         default: begin
            mul_op   = '0;
            mul_gain = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_op) * signed'(PROD_W'(mul_gain));

   always_comb begin
      case (ctrl.acc_op)
         ACC_CLR: acc_in = '0;
         ACC_ADD: acc_in = acc_ff + ACC_W'(prod_ff);
         default: acc_in = acc_ff;
      endcase
   end

   // Truncate toward zero to whole units and clamp to the drive range.
   always_comb begin
      if (acc_ff <= 0) begin
         drive = '0;
      end else if (acc_ff[ACC_W-2:Q_FRAC] > (ACC_W-1-Q_FRAC)'(DRIVE_MAX)) begin
         drive = DRIVE_MAX;
      end else begin
         drive = acc_ff[Q_FRAC +: DRIVE_W];
      end
   end

   assign out_free = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctrl.upd_state) begin
            last_err_ff <= err_ff;
            sum_ff      <= sum_in;
         end
         if (ctrl.emit && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_err && in_valid) begin
         err_ff <= err_in;
      end
      if (ctrl.upd_state) begin
         chg_ff <= CHG_W'(err_ff) - CHG_W'(last_err_ff);
      end
      if (ctrl.emit && out_free) begin
         out_drive_ff <= drive;
      end
      sumc_ff <= sumc_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign out_valid     = out_valid_ff;
   assign out_drive     = out_drive_ff;
   assign cond.in_valid = in_valid;
   assign cond.out_free = out_free;

endmodule

// ----- sv/pid_temperature_fan_drive.sv -----
// ----------------------------------------------------------------------------
// PID temperature fan drive
// Converts an ADC sample to Q10 degrees and drives a fan from a PID law.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   -------  ---------  ---------------------------------------------------
//   req_     in         tdata: adc_sample (ADC_BITS bits, zero padded)
//   rsp_     out        tdata: drive_level (8 bits)
//   csr_     in         write of gain_p, gain_i, gain_d or target_celsius
//
// The result beat follows its input beat at a pace set by the
// control program: the fetch step captures the error, one step updates the
// sum and the error change, three run the single shared gain multiplier and
// one more folds in the last product before the result is loaded. The
// program returns to the fetch step on the edge that loads the result, so
// the next sample is taken only once this result is loaded. Reset is synchronous and
// clears the step counter, the error history, the integral sum and the
// result valid flag; gains and setpoint return to their reset values. A
// result that waits on rsp_tready does not close the input: the next sample
// is taken and processed meanwhile. Only when that next result is due while
// the earlier one still waits does the program hold at its final step, and
// the input stays closed until rsp_tready frees the result register.
//
module pid_temperature_fan_drive
   import ptfd_pkg::*;
#(
   parameter int ADC_BITS  = 10,
   parameter int SUM_WIDTH = 40,
   localparam int REQ_W    = ((ADC_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // [ADC_BITS-1:0] adc_sample
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DRIVE_W-1:0]   rsp_tdata,   // [7:0] drive_level
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   cfg_type  cfg_ff;
   ctrl_type ctrl;
   cond_type cond;

   // Configuration registers. Writes to indexes past the setpoint are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p <= RST_GAIN_P;
         cfg_ff.gain_i <= RST_GAIN_I;
         cfg_ff.gain_d <= RST_GAIN_D;
         cfg_ff.target <= RST_TARGET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GAIN_P: cfg_ff.gain_p <= csr_wdata;
            CSR_GAIN_I: cfg_ff.gain_i <= csr_wdata;
            CSR_GAIN_D: cfg_ff.gain_d <= csr_wdata;
            CSR_TARGET: cfg_ff.target <= csr_wdata;
            default: ;
         endcase
      end
   end

   ptfd_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   ptfd_datapath #(
      .ADC_BITS  (ADC_BITS),
      .SUM_WIDTH (SUM_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .adc       (req_tdata[ADC_BITS-1:0]),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_drive (rsp_tdata),
      .cond      (cond)
   );

   // The input is taken only at the fetch step of the program.
   assign req_tready = ctrl.wait_in;

endmodule

// ----- sv/ptfd_checker.sv -----
// ----------------------------------------------------------------------------
// PID fan drive port checker
// Concurrent checks on the top level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "pid_temperature_fan_drive_macros.svh"

module ptfd_checker
   import ptfd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [DRIVE_W-1:0] rsp_tdata
);

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // A stalled result beat keeps its value.
   `PTFD_ASSERT_NXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata),
      "stalled result beat changed")

   // One sample at a time: the input closes right after a beat is taken.
   `PTFD_ASSERT_NXT(a_one_in_flight, clock, reset,
      req_beat, !req_tready,
      "input taken on consecutive cycles")

   // A result never follows its sample in the very next cycle.
   `PTFD_ASSERT_NXT(a_no_early_rsp, clock, reset,
      req_beat && !rsp_tvalid, !rsp_tvalid,
      "result appeared too early")

   // Reset leaves no result pending and the input open.
   `PTFD_ASSERT_NXT(a_reset_state, clock, 1'b0,
      reset, !rsp_tvalid && req_tready,
      "bad state after reset")

endmodule

bind pid_temperature_fan_drive ptfd_checker u_ptfd_checker (.*);
